// File: hdl/abdi_pkg.sv
// abdi_pkg: shared types, constants, microcode table and saturation helper
// for the accel bias correct double integrator core
// no dependencies
package abdi_pkg;

  localparam int AXES      = 3;
  localparam int FRAC_BITS = 16;
  localparam int STEP_FRAC = 16;
  localparam int AXIS_W    = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int PC_W      = 3;
  localparam int DATA_W    = 32;
  localparam int STEP_W    = 16;
  localparam int IDX_W     = 3;
  localparam int WIDE_W    = 66;

  localparam logic [IDX_W-1:0] REG_BIAS_X    = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_X    = 3'd3;
  localparam logic [IDX_W-1:0] REG_TIME_STEP = 3'd6;

  localparam logic signed [DATA_W-1:0] GAIN_RESET = 32'sd65536;
  localparam logic [STEP_W-1:0]        STEP_RESET = 16'd655;

  typedef enum logic [2:0] {
    OP_SUB,
    OP_MULG,
    OP_ACC,
    OP_MULA,
    OP_VEL,
    OP_MULV,
    OP_POS,
    OP_DONE
  } op_e;

  typedef struct packed {
    op_e  op;
    logic loop;
  } uword_t;

  typedef struct packed {
    logic              busy;
    op_e               op;
    logic [AXIS_W-1:0] axis;
    logic              finish;
  } ctrl_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w.loop = 1'b0;
    unique case (pc)
      3'd0: w.op = OP_SUB;
      3'd1: w.op = OP_MULG;
      3'd2: w.op = OP_ACC;
      3'd3: w.op = OP_MULA;
      3'd4: w.op = OP_VEL;
      3'd5: w.op = OP_MULV;
      3'd6: begin
        w.op   = OP_POS;
        w.loop = 1'b1;
      end
      3'd7: w.op = OP_DONE;
      default: w.op = OP_DONE;
    endcase
    return w;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(32'sh7fffffff);
    lo = -WIDE_W'(33'sh080000000);
    if (x > hi) begin
      return 32'sh7fffffff;
    end else if (x < lo) begin
      return 32'sh80000000;
    end else begin
      return x[DATA_W-1:0];
    end
  endfunction

endpackage

// File: hdl/abdi_seq.sv
// abdi_seq: microcode sequencer, step counter, axis loop and busy flag
// depends on abdi_pkg (control word table and ctrl_t)
module abdi_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           out_free_i,
  output abdi_pkg::ctrl_t ctrl_o
);

  logic [abdi_pkg::PC_W-1:0]   pc_q, pc_d;
  logic [abdi_pkg::AXIS_W-1:0] axis_q, axis_d;
  logic                        busy_q, busy_d;
  abdi_pkg::uword_t            word;
  logic                        last_axis;

  assign word      = abdi_pkg::ucode(pc_q);
  assign last_axis = (axis_q == abdi_pkg::AXIS_W'(abdi_pkg::AXES - 1));

  always_comb begin
    pc_d   = pc_q;
    axis_d = axis_q;
    busy_d = busy_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = '0;
        axis_d = '0;
      end
    end else if (word.op == abdi_pkg::OP_DONE) begin
      if (out_free_i) begin
        busy_d = 1'b0;
      end
    end else if (word.loop && !last_axis) begin
      pc_d   = '0;
      axis_d = axis_q + 1'b1;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      axis_q <= '0;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      axis_q <= axis_d;
      busy_q <= busy_d;
    end
  end

  always_comb begin
    ctrl_o.busy   = busy_q;
    ctrl_o.op     = word.op;
    ctrl_o.axis   = axis_q;
    ctrl_o.finish = busy_q && (word.op == abdi_pkg::OP_DONE) && out_free_i;
  end

endmodule

// File: hdl/accel_bias_correct_double_integrator_core.sv
// accel_bias_correct_double_integrator_core: top level with config registers,
// shared multiplier datapath, integrator state and output register
// depends on abdi_pkg and abdi_seq
//
// Usage
// - input request: three raw acceleration axes (signed Q16.16), valid/ready
// - output request: corrected acceleration and integrated position per axis
// - config: cfg_we_i writes cfg_wdata_i to register cfg_index_i (0..2 bias,
//   3..5 gain, 6 time step); unknown indexes are dropped
// - per axis the sequencer runs seven steps around one 33x33 multiplier:
//   subtract, multiply by gain, saturate, multiply by step, velocity update,
//   multiply by step, position update; one more step hands off the result
// - a new request is accepted only while the sequencer is idle, that is
//   once the previous one has passed its hand-off step; the pace is set by
//   the single multiplier and the microcode loop
// - the finished result sits in an output register, so the next request is
//   taken while it waits; if it is still not taken when the next result is
//   ready, the sequencer holds on its hand-off step
// - reset clears velocity and position, restores bias 0, gain 1.0, step 655
module accel_bias_correct_double_integrator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [abdi_pkg::IDX_W-1:0]         cfg_index_i,
  input  logic [abdi_pkg::DATA_W-1:0]        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [abdi_pkg::DATA_W-1:0] accel_in_x_i,
  input  logic signed [abdi_pkg::DATA_W-1:0] accel_in_y_i,
  input  logic signed [abdi_pkg::DATA_W-1:0] accel_in_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [abdi_pkg::DATA_W-1:0] accel_out_x_o,
  output logic signed [abdi_pkg::DATA_W-1:0] accel_out_y_o,
  output logic signed [abdi_pkg::DATA_W-1:0] accel_out_z_o,
  output logic signed [abdi_pkg::DATA_W-1:0] pos_out_x_o,
  output logic signed [abdi_pkg::DATA_W-1:0] pos_out_y_o,
  output logic signed [abdi_pkg::DATA_W-1:0] pos_out_z_o
);

  localparam int W  = abdi_pkg::DATA_W;
  localparam int WW = abdi_pkg::WIDE_W;
  localparam int NA = abdi_pkg::AXES;

  abdi_pkg::ctrl_t ctrl;

  logic signed [W-1:0]           bias_q [NA];
  logic signed [W-1:0]           gain_q [NA];
  logic [abdi_pkg::STEP_W-1:0]   ts_q;
  logic signed [W-1:0]           vel_q  [NA];
  logic signed [W-1:0]           pos_q  [NA];
  logic signed [W-1:0]           in_q   [NA];
  logic signed [W-1:0]           acc_q  [NA];
  logic signed [W-1:0]           acc_out_q [NA];
  logic signed [W-1:0]           pos_out_q [NA];
  logic signed [W-1:0]           in_port [3];
  logic signed [W-1:0]           acc_port [3];
  logic signed [W-1:0]           pos_port [3];
  logic signed [W-1:0]           d_q;
  logic signed [WW-1:0]          prod_q;
  logic signed [W:0]             mul_a;
  logic signed [W:0]             mul_b;
  logic signed [WW-1:0]          prod;
  logic signed [W:0]             diff;
  logic signed [WW-1:0]          step_sh;
  logic signed [W-1:0]           sub_d, acc_d, vel_d, pos_d;
  logic                          out_valid_q;
  logic                          in_acc;
  logic [abdi_pkg::AXIS_W-1:0]   ax;

  assign in_port[0] = accel_in_x_i;
  assign in_port[1] = accel_in_y_i;
  assign in_port[2] = accel_in_z_i;

  assign in_ready_o = !ctrl.busy;
  assign in_acc     = in_valid_i && in_ready_o;
  assign ax         = ctrl.axis;

  abdi_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .out_free_i (!out_valid_q || out_ready_i),
    .ctrl_o     (ctrl)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NA; k++) begin
        bias_q[k] <= '0;
        gain_q[k] <= abdi_pkg::GAIN_RESET;
      end
      ts_q <= abdi_pkg::STEP_RESET;
    end else if (cfg_we_i) begin
      for (int k = 0; k < NA; k++) begin
        if (cfg_index_i == abdi_pkg::IDX_W'(abdi_pkg::REG_BIAS_X + k)) begin
          bias_q[k] <= cfg_wdata_i;
        end
        if (cfg_index_i == abdi_pkg::IDX_W'(abdi_pkg::REG_GAIN_X + k)) begin
          gain_q[k] <= cfg_wdata_i;
        end
      end
      if (cfg_index_i == abdi_pkg::REG_TIME_STEP) begin
        ts_q <= cfg_wdata_i[abdi_pkg::STEP_W-1:0];
      end
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = {acc_q[ax][W-1], acc_q[ax]};
    mul_b = (W+1)'({1'b0, ts_q});
    case (ctrl.op)
      abdi_pkg::OP_MULG: begin
        mul_a = {d_q[W-1], d_q};
        mul_b = {gain_q[ax][W-1], gain_q[ax]};
      end
      abdi_pkg::OP_MULV: mul_a = {vel_q[ax][W-1], vel_q[ax]};
      default: ;
    endcase
  end

  assign prod    = WW'(mul_a) * WW'(mul_b);
  assign diff    = {in_q[ax][W-1], in_q[ax]} - {bias_q[ax][W-1], bias_q[ax]};
  assign sub_d   = abdi_pkg::sat32(WW'(diff));
  assign acc_d   = abdi_pkg::sat32(prod_q >>> abdi_pkg::FRAC_BITS);
  assign step_sh = prod_q >>> abdi_pkg::STEP_FRAC;
  assign vel_d   = abdi_pkg::sat32(WW'(vel_q[ax]) + step_sh);
  assign pos_d   = abdi_pkg::sat32(WW'(pos_q[ax]) + step_sh);

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int k = 0; k < NA; k++) begin
        in_q[k] <= in_port[k];
      end
    end
    if (ctrl.finish) begin
      for (int k = 0; k < NA; k++) begin
        acc_out_q[k] <= acc_q[k];
        pos_out_q[k] <= pos_q[k];
      end
    end
    if (ctrl.busy) begin
      case (ctrl.op) inside
        abdi_pkg::OP_SUB: d_q <= sub_d;
        abdi_pkg::OP_MULG,
        abdi_pkg::OP_MULA,
        abdi_pkg::OP_MULV: prod_q <= prod;
        abdi_pkg::OP_ACC: acc_q[ax] <= acc_d;
        default: ;
      endcase
    end
  end

  // integrator state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NA; k++) begin
        vel_q[k] <= '0;
        pos_q[k] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.busy && ctrl.op == abdi_pkg::OP_VEL) begin
        vel_q[ax] <= vel_d;
      end
      if (ctrl.busy && ctrl.op == abdi_pkg::OP_POS) begin
        pos_q[ax] <= pos_d;
      end
      if (ctrl.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // inactive axes report zero
  for (genvar g = 0; g < 3; g++) begin : g_out
    if (g < NA) begin : g_on
      assign acc_port[g] = acc_out_q[g];
      assign pos_port[g] = pos_out_q[g];
    end else begin : g_off
      assign acc_port[g] = '0;
      assign pos_port[g] = '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign accel_out_x_o = acc_port[0];
  assign accel_out_y_o = acc_port[1];
  assign accel_out_z_o = acc_port[2];
  assign pos_out_x_o   = pos_port[0];
  assign pos_out_y_o   = pos_port[1];
  assign pos_out_z_o   = pos_port[2];

  a_start_sub : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (ctrl.busy && ctrl.op == abdi_pkg::OP_SUB && ctrl.axis == '0))
    else $error("sequencer did not start with subtraction on first axis");

  a_valid_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(ctrl.finish))
    else $error("result raised without a hand-off step");

  a_zero_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.busy && ctrl.op == abdi_pkg::OP_MULA && ts_q == '0) |=> (prod_q == '0))
    else $error("zero time step gave nonzero product");

endmodule
